// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, masked while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/rfc_pkg.sv =====
// Types and constants of the response frame checker.
// No dependencies; used by the verdict channel interface, decoder and top level.
package rfc_pkg;

	localparam logic [7:0] FRAME_DELIM  = 8'hC0;
	localparam logic [7:0] FRAME_ESCAPE = 8'hDB;
	localparam logic [7:0] ESC_DELIM    = 8'hDC;
	localparam logic [7:0] ESC_ESCAPE   = 8'hDD;
	localparam logic [7:0] DIR_RESPONSE = 8'h01;
	localparam logic [7:0] STATUS_OK    = 8'h00;
	localparam int unsigned MIN_LENGTH  = 10;
	localparam int unsigned LEN_W       = 7;

	typedef enum logic [2:0] {
		V_OK        = 3'd0,
		V_TIMEOUT   = 3'd1,
		V_SHORT     = 3'd2,
		V_DIRECTION = 3'd3,
		V_COMMAND   = 3'd4,
		V_STATUS    = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [LEN_W-1:0]   frame_length;
		logic [7:0]         status_byte;
		logic [7:0]         error_byte;
	} result_t;

endpackage

// ===== rtl/core/rfc_in_if.sv =====
// Receive byte channel: valid/ready handshake with byte and timeout flag.
// No dependencies.
interface rfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       timed_out;

	modport source (output valid, output rx_byte, output timed_out, input ready);
	modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

// ===== rtl/core/rfc_out_if.sv =====
// Verdict channel: valid/ready handshake with one verdict transaction per frame.
// Depends on rfc_pkg for the field width.
interface rfc_out_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               verdict;
	logic [rfc_pkg::LEN_W-1:0] frame_length;
	logic [7:0]               status_byte;
	logic [7:0]               error_byte;

	modport source (output valid, output verdict, output frame_length, output status_byte,
		output error_byte, input ready);
	modport sink (input valid, input verdict, input frame_length, input status_byte,
		input error_byte, output ready);
endinterface

// ===== rtl/core/response_frame_checker_unit.sv =====
// Response frame checker: SLIP reply decoder with one verdict per frame.
// An accepted byte passes the input register, the decoder and the result register to the result channel.
// Throughput: 1 byte per cycle, set by the single decode pass between the input
// register and the result register; stalls only while a verdict waits unread.
// Reset (arst_n, async low): hunting for delimiter, expected_command 0, channels empty.
// Depends on rfc_pkg, rfc_in_if, rfc_out_if, rfc_decoder and assert_macros.svh.
`include "assert_macros.svh"

module response_frame_checker_unit #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	rfc_in_if.sink     rx,
	rfc_out_if.source  result
);
	import rfc_pkg::*;

	logic [7:0] expected_command_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       tmo_s1;
	logic       adv;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_command_q <= '0;
		end else if (cfg_we) begin
			expected_command_q <= cfg_wdata;
		end
	end

	assign adv      = !out_valid_q || result.ready;
	assign rx.ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			tmo_s1  <= rx.timed_out;
		end
	end

	rfc_decoder #(
		.MAX_FRAME(MAX_FRAME)
	) u_decoder (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.rx_byte          (byte_s1),
		.timed_out        (tmo_s1),
		.expected_command (expected_command_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.verdict      = out_q.verdict;
	assign result.frame_length = out_q.frame_length;
	assign result.status_byte  = out_q.status_byte;
	assign result.error_byte   = out_q.error_byte;

	`ASSERT_CLKD(a_tmo_verdict, clk, arst_n, step && tmo_s1 |=> result.valid && result.verdict == V_TIMEOUT, "timeout transaction did not yield a timeout verdict")
	`ASSERT_CLKD(a_tmo_fields, clk, arst_n, result.valid && result.verdict == V_TIMEOUT |-> result.frame_length == '0 && result.status_byte == '0 && result.error_byte == '0, "timeout verdict with nonzero fields")
	`ASSERT_CLKD(a_ok_status, clk, arst_n, result.valid && result.verdict == V_OK |-> result.status_byte == STATUS_OK, "ok verdict with failing status byte")

endmodule

// ===== rtl/core/rfc_decoder.sv =====
// SLIP frame state and per-byte decode/check logic.
// Depends on rfc_pkg.
module rfc_decoder #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic             timed_out,
	input  logic [7:0]       expected_command,
	output logic             res_valid,
	output rfc_pkg::result_t res
);
	import rfc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	logic             in_frame_q, esc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       dir_q, cmd_q, prev_q, lat_q;

	logic             n_in, n_esc;
	logic [CNT_W-1:0] n_cnt;
	logic [7:0]       n_dir, n_cmd, n_prev, n_lat;
	logic             do_store, finish;
	logic [7:0]       sb;

	always_comb begin
		n_in     = in_frame_q;
		n_esc    = esc_q;
		n_cnt    = cnt_q;
		n_dir    = dir_q;
		n_cmd    = cmd_q;
		n_prev   = prev_q;
		n_lat    = lat_q;
		do_store = 1'b0;
		finish   = 1'b0;
		sb       = rx_byte;
		res_valid = 1'b0;
		res.verdict      = V_OK;
		res.frame_length = '0;
		res.status_byte  = '0;
		res.error_byte   = '0;

		if (step) begin
			if (timed_out) begin
				res_valid   = 1'b1;
				res.verdict = V_TIMEOUT;
				n_in   = 1'b0;
				n_esc  = 1'b0;
				n_cnt  = '0;
				n_dir  = '0;
				n_cmd  = '0;
				n_prev = '0;
				n_lat  = '0;
			end else if (!in_frame_q) begin
				if (rx_byte == FRAME_DELIM) begin
					n_in   = 1'b1;
					n_esc  = 1'b0;
					n_cnt  = '0;
					n_dir  = '0;
					n_cmd  = '0;
					n_prev = '0;
					n_lat  = '0;
				end
			end else if (esc_q) begin
				n_esc    = 1'b0;
				do_store = 1'b1;
				case (rx_byte)
					ESC_DELIM:  sb = FRAME_DELIM;
					ESC_ESCAPE: sb = FRAME_ESCAPE;
					default:    sb = rx_byte;
				endcase
			end else if (rx_byte == FRAME_ESCAPE) begin
				n_esc = 1'b1;
			end else if (rx_byte == FRAME_DELIM) begin
				finish = 1'b1;
			end else begin
				do_store = 1'b1;
			end
		end

		if (do_store) begin
			if (cnt_q == '0) begin
				n_dir = sb;
			end else if (cnt_q == CNT_W'(1)) begin
				n_cmd = sb;
			end
			n_prev = lat_q;
			n_lat  = sb;
			n_cnt  = cnt_q + CNT_W'(1);
			if (n_cnt >= CNT_W'(MAX_FRAME)) begin
				finish = 1'b1;
			end
		end

		if (finish) begin
			res_valid = 1'b1;
			if (n_cnt < CNT_W'(MIN_LENGTH)) begin
				res.verdict = V_SHORT;
			end else if (n_dir != DIR_RESPONSE) begin
				res.verdict = V_DIRECTION;
			end else if (n_cmd != expected_command) begin
				res.verdict = V_COMMAND;
			end else if (n_prev != STATUS_OK) begin
				res.verdict = V_STATUS;
			end else begin
				res.verdict = V_OK;
			end
			res.frame_length = LEN_W'({{LEN_W{1'b0}}, n_cnt});
			res.status_byte  = n_prev;
			res.error_byte   = n_lat;
			n_in   = 1'b0;
			n_esc  = 1'b0;
			n_cnt  = '0;
			n_dir  = '0;
			n_cmd  = '0;
			n_prev = '0;
			n_lat  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cnt_q      <= '0;
			dir_q      <= '0;
			cmd_q      <= '0;
			prev_q     <= '0;
			lat_q      <= '0;
		end else begin
			in_frame_q <= n_in;
			esc_q      <= n_esc;
			cnt_q      <= n_cnt;
			dir_q      <= n_dir;
			cmd_q      <= n_cmd;
			prev_q     <= n_prev;
			lat_q      <= n_lat;
		end
	end

endmodule
